// ===== rtl/core/terminal_key_sequence_decoder_top_assert.svh =====
// assertion macros for the terminal key decoder checker
// depends on nothing; included by the checker file
`ifndef TERMINAL_KEY_SEQUENCE_DECODER_TOP_ASSERT_SVH
`define TERMINAL_KEY_SEQUENCE_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define TKSD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/tksd_pkg.sv =====
// package for the terminal key sequence decoder: types, key codes, constants
// no dependencies
package tksd_pkg;

    typedef enum logic [4:0] {
        PH_IDLE  = 5'b00001,
        PH_ESC   = 5'b00010,
        PH_CSI   = 5'b00100,
        PH_DIGIT = 5'b01000,
        PH_UTF8  = 5'b10000
    } phase_t;

    localparam logic [3:0] KT_ESC       = 4'd0;
    localparam logic [3:0] KT_UP        = 4'd1;
    localparam logic [3:0] KT_DOWN      = 4'd2;
    localparam logic [3:0] KT_RIGHT     = 4'd3;
    localparam logic [3:0] KT_LEFT      = 4'd4;
    localparam logic [3:0] KT_HOME      = 4'd5;
    localparam logic [3:0] KT_END       = 4'd6;
    localparam logic [3:0] KT_TAB       = 4'd7;
    localparam logic [3:0] KT_PAGE_UP   = 4'd8;
    localparam logic [3:0] KT_PAGE_DOWN = 4'd9;
    localparam logic [3:0] KT_UNKNOWN   = 4'd10;
    localparam logic [3:0] KT_RETURN    = 4'd11;
    localparam logic [3:0] KT_ERASE     = 4'd12;
    localparam logic [3:0] KT_CONTROL   = 4'd13;
    localparam logic [3:0] KT_TEXT      = 4'd14;

    localparam logic [2:0] DIG_OTHER = 3'd0;
    localparam logic [2:0] DIG_ONE   = 3'd1;
    localparam logic [2:0] DIG_FOUR  = 3'd2;
    localparam logic [2:0] DIG_FIVE  = 3'd3;
    localparam logic [2:0] DIG_SIX   = 3'd4;

    localparam logic       OP_BYTE = 1'b0;
    localparam logic       OP_TICK = 1'b1;

    localparam int         CP_W = 21;
    localparam logic [CP_W-1:0] BAD_CP = 21'h00FFFD;
    localparam logic [15:0] TIMEOUT_RESET = 16'd30;
    localparam logic [15:0] TICK_MAX      = 16'hFFFF;

    typedef struct packed {
        phase_t          phase;
        logic [2:0]      digit;
        logic [CP_W-1:0] acc;
        logic [1:0]      remaining;
        logic            malformed;
        logic [15:0]     ticks;
    } state_t;

    typedef struct packed {
        logic            valid;
        logic [3:0]      key;
        logic [CP_W-1:0] cp;
    } result_t;

endpackage

// ===== rtl/core/tksd_decode.sv =====
// next-state and result logic for one transaction of the key decoder
// depends on tksd_pkg
module tksd_decode
(
    input  tksd_pkg::state_t  st,
    input  logic              opcode,
    input  logic [7:0]        byte_value,
    input  logic [15:0]       timeout_ticks,
    output tksd_pkg::state_t  st_next,
    output tksd_pkg::result_t res
);

    logic [15:0]               ticks_inc;
    logic                      is_cont;
    logic                      bad_next;
    logic [1:0]                rem_next;
    logic [tksd_pkg::CP_W-1:0] acc_next;

    assign ticks_inc = (st.ticks == tksd_pkg::TICK_MAX) ? st.ticks : st.ticks + 16'd1;
    assign is_cont   = (byte_value[7:6] == 2'b10);
    assign bad_next  = st.malformed | ~is_cont;
    assign rem_next  = (st.remaining != 2'd0) ? st.remaining - 2'd1 : 2'd0;
    assign acc_next  = (is_cont && !st.malformed)
                     ? {st.acc[tksd_pkg::CP_W-7:0], byte_value[5:0]} : st.acc;

    always_comb
    begin
        st_next   = st;
        res.valid = 1'b0;
        res.key   = tksd_pkg::KT_ESC;
        res.cp    = '0;
        if (opcode == tksd_pkg::OP_TICK)
        begin
            case (st.phase)
                tksd_pkg::PH_ESC, tksd_pkg::PH_CSI, tksd_pkg::PH_DIGIT, tksd_pkg::PH_UTF8:
                begin
                    st_next.ticks = ticks_inc;
                    if (ticks_inc >= timeout_ticks)
                    begin
                        res.valid = 1'b1;
                        if (st.phase == tksd_pkg::PH_DIGIT)
                            res.key = tksd_pkg::KT_UNKNOWN;
                        else if (st.phase == tksd_pkg::PH_UTF8)
                        begin
                            res.key = tksd_pkg::KT_TEXT;
                            res.cp  = tksd_pkg::BAD_CP;
                        end
                    end
                end
                default:
                begin
                    st_next.phase = tksd_pkg::PH_IDLE;
                end
            endcase
        end
        else
        begin
            st_next.ticks = '0;
            case (st.phase)
                tksd_pkg::PH_ESC:
                begin
                    if (byte_value == 8'h5B || byte_value == 8'h4F)
                        st_next.phase = tksd_pkg::PH_CSI;
                    else
                        res.valid = 1'b1;
                end
                tksd_pkg::PH_CSI:
                begin
                    res.valid = 1'b1;
                    case (byte_value)
                        8'h41: res.key = tksd_pkg::KT_UP;
                        8'h42: res.key = tksd_pkg::KT_DOWN;
                        8'h43: res.key = tksd_pkg::KT_RIGHT;
                        8'h44: res.key = tksd_pkg::KT_LEFT;
                        8'h48: res.key = tksd_pkg::KT_HOME;
                        8'h46: res.key = tksd_pkg::KT_END;
                        8'h5A:
                        begin
                            res.key = tksd_pkg::KT_TAB;
                            res.cp  = 21'd1;
                        end
                        default:
                        begin
                            if (byte_value >= 8'h30 && byte_value <= 8'h39)
                            begin
                                res.valid     = 1'b0;
                                st_next.phase = tksd_pkg::PH_DIGIT;
                                case (byte_value)
                                    8'h31:   st_next.digit = tksd_pkg::DIG_ONE;
                                    8'h34:   st_next.digit = tksd_pkg::DIG_FOUR;
                                    8'h35:   st_next.digit = tksd_pkg::DIG_FIVE;
                                    8'h36:   st_next.digit = tksd_pkg::DIG_SIX;
                                    default: st_next.digit = tksd_pkg::DIG_OTHER;
                                endcase
                            end
                            else
                                res.key = tksd_pkg::KT_UNKNOWN;
                        end
                    endcase
                end
                tksd_pkg::PH_DIGIT:
                begin
                    res.valid = 1'b1;
                    res.key   = tksd_pkg::KT_UNKNOWN;
                    if (byte_value == 8'h7E)
                    begin
                        case (st.digit)
                            tksd_pkg::DIG_ONE:  res.key = tksd_pkg::KT_HOME;
                            tksd_pkg::DIG_FOUR: res.key = tksd_pkg::KT_END;
                            tksd_pkg::DIG_FIVE: res.key = tksd_pkg::KT_PAGE_UP;
                            tksd_pkg::DIG_SIX:  res.key = tksd_pkg::KT_PAGE_DOWN;
                            default:            res.key = tksd_pkg::KT_UNKNOWN;
                        endcase
                    end
                end
                tksd_pkg::PH_UTF8:
                begin
                    st_next.malformed = bad_next;
                    st_next.acc       = acc_next;
                    st_next.remaining = rem_next;
                    if (rem_next == 2'd0)
                    begin
                        res.valid = 1'b1;
                        res.key   = tksd_pkg::KT_TEXT;
                        res.cp    = bad_next ? tksd_pkg::BAD_CP : acc_next;
                    end
                end
                default:
                begin
                    st_next.phase = tksd_pkg::PH_IDLE;
                    res.valid     = 1'b1;
                    if (byte_value == 8'h1B)
                    begin
                        res.valid     = 1'b0;
                        st_next.phase = tksd_pkg::PH_ESC;
                    end
                    else if (byte_value == 8'h0D || byte_value == 8'h0A)
                        res.key = tksd_pkg::KT_RETURN;
                    else if (byte_value == 8'h7F || byte_value == 8'h08)
                        res.key = tksd_pkg::KT_ERASE;
                    else if (byte_value == 8'h09)
                        res.key = tksd_pkg::KT_TAB;
                    else if (byte_value < 8'h20)
                    begin
                        res.key = tksd_pkg::KT_CONTROL;
                        res.cp  = {13'd0, 8'h60 + byte_value};
                    end
                    else if (byte_value < 8'h80)
                    begin
                        res.key = tksd_pkg::KT_TEXT;
                        res.cp  = {13'd0, byte_value};
                    end
                    else if (byte_value[7:5] == 3'b110 || byte_value[7:4] == 4'b1110
                             || byte_value[7:3] == 5'b11110)
                    begin
                        res.valid         = 1'b0;
                        st_next.phase     = tksd_pkg::PH_UTF8;
                        st_next.malformed = 1'b0;
                        if (byte_value[7:5] == 3'b110)
                        begin
                            st_next.acc       = {16'd0, byte_value[4:0]};
                            st_next.remaining = 2'd1;
                        end
                        else if (byte_value[7:4] == 4'b1110)
                        begin
                            st_next.acc       = {17'd0, byte_value[3:0]};
                            st_next.remaining = 2'd2;
                        end
                        else
                        begin
                            st_next.acc       = {18'd0, byte_value[2:0]};
                            st_next.remaining = 2'd3;
                        end
                    end
                    else
                    begin
                        res.key = tksd_pkg::KT_TEXT;
                        res.cp  = tksd_pkg::BAD_CP;
                    end
                end
            endcase
        end
        if (res.valid)
        begin
            st_next.phase = tksd_pkg::PH_IDLE;
            st_next.ticks = '0;
        end
    end

endmodule

// ===== rtl/core/terminal_key_sequence_decoder_top.sv =====
// a result passes from the input registers through the decode logic into the output registers
// throughput: one transaction per cycle while m_axis_tready stays high
// the rate is set by one decode pass between the input and result registers
// reset: rst_n clears decoder state and valid flags; timeout_ticks returns to 30
// depends on tksd_pkg and tksd_decode
module terminal_key_sequence_decoder_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // byte_value
    input  logic        s_axis_tuser,   // opcode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // code_point, zero pad
    output logic [3:0]  m_axis_tuser,   // key_type
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic                      in_valid_reg;
    logic                      in_opcode_reg;
    logic [7:0]                in_byte_reg;
    tksd_pkg::state_t          state_reg;
    tksd_pkg::state_t          state_next;
    tksd_pkg::result_t         res;
    logic                      out_valid_reg;
    logic [3:0]                out_key_reg;
    logic [tksd_pkg::CP_W-1:0] out_cp_reg;
    logic [15:0]               timeout_reg;
    logic                      out_free;
    logic                      advance;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    tksd_decode u_decode
    (
        .st            (state_reg),
        .opcode        (in_opcode_reg),
        .byte_value    (in_byte_reg),
        .timeout_ticks (timeout_reg),
        .st_next       (state_next),
        .res           (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            timeout_reg   <= tksd_pkg::TIMEOUT_RESET;
            state_reg     <= '{phase: tksd_pkg::PH_IDLE, digit: '0, acc: '0,
                               remaining: '0, malformed: 1'b0, ticks: '0};
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                timeout_reg <= cfg_data;
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                state_reg <= state_next;
            if (out_free)
                out_valid_reg <= advance && res.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_opcode_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata;
        end
        if (advance && res.valid)
        begin
            out_key_reg <= res.key;
            out_cp_reg  <= res.cp;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_key_reg;
    assign m_axis_tdata  = {3'd0, out_cp_reg};

endmodule

// ===== rtl/core/tksd_checker.sv =====
// port-level checker for the terminal key decoder, bound to the top level
// depends on tksd_pkg and terminal_key_sequence_decoder_top_assert.svh
`include "terminal_key_sequence_decoder_top_assert.svh"

module tksd_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    `TKSD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "output transaction dropped while stalled")
    `TKSD_ASSERT_NOW(a_key_range, clk, rst_n, m_axis_tvalid, m_axis_tuser <= tksd_pkg::KT_TEXT, "key type out of range")
    `TKSD_ASSERT_NOW(a_cp_zero, clk, rst_n, m_axis_tvalid && m_axis_tuser != tksd_pkg::KT_TEXT && m_axis_tuser != tksd_pkg::KT_CONTROL && m_axis_tuser != tksd_pkg::KT_TAB, m_axis_tdata == 24'd0, "nonzero code point on plain key")
    `TKSD_ASSERT_NOW(a_ctrl_range, clk, rst_n, m_axis_tvalid && m_axis_tuser == tksd_pkg::KT_CONTROL, m_axis_tdata >= 24'h60 && m_axis_tdata <= 24'h7F, "control letter out of range")

endmodule

bind terminal_key_sequence_decoder_top tksd_checker u_tksd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
